@@ design/sfl_pkg.sv @@
// Package for the slab free-list pool: field widths, codes, payload structs
// and the internal command and divider types. No dependencies.
package sfl_pkg;

  localparam int ADDR_W      = 32;
  localparam int SIZE_W      = 13;
  localparam int PAGES_W     = 4;
  localparam int IN_USE_W    = 11;
  localparam int STATUS_W    = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int PAGE_SHIFT  = 12;
  localparam int REL_W       = PAGES_W + PAGE_SHIFT;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [ADDR_W-1:0]  PAGE_MASK       = 32'hfffff000;
  localparam logic [SIZE_W-1:0]  MIN_SLOT        = 13'd8;
  localparam logic [ADDR_W-1:0]  RESET_BASE      = 32'h0;
  localparam logic [SIZE_W-1:0]  RESET_SLOT_SIZE = 13'd8;
  localparam logic [PAGES_W-1:0] RESET_PAGES     = 4'd1;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE       = 2'd0,
    CFG_SLOT_SIZE  = 2'd1,
    CFG_PAGE_COUNT = 2'd2
  } cfg_idx_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 3'd0,
    ST_SIZE_MISMATCH = 3'd1,
    ST_FULL          = 3'd2,
    ST_OUTSIDE       = 3'd3,
    ST_NONE_OUT      = 3'd4,
    ST_MISALIGNED    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    BK_CNT_START,
    BK_CNT_WAIT,
    BK_SWEEP,
    BK_IDLE,
    BK_ALLOC,
    BK_FREE_WAIT
  } back_state_e;

  typedef struct packed {
    logic              req_type;
    logic [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0] free_address;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   slot_address;
    logic [IN_USE_W-1:0] in_use;
  } rsp_t;

  typedef struct packed {
    logic             is_free;
    status_e          pre_status;
    logic [REL_W-1:0] rel;
  } cmd_t;

  typedef struct packed {
    logic              start;
    logic [REL_W-1:0]  dividend_a;
    logic [REL_W-1:0]  dividend_b;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [REL_W-1:0]  quo_a;
    logic [SIZE_W-1:0] rem_a;
    logic [SIZE_W-1:0] rem_b;
  } div_rsp_t;

endpackage

@@ design/sfl_front.sv @@
// Front end of the slab pool: accepts a request and classifies it against
// the configuration into a queued command. Depends on sfl_pkg.
module sfl_front import sfl_pkg::*; (
  input  logic               start_i,
  input  logic               busy_i,
  input  req_t               req_i,
  input  logic [ADDR_W-1:0]  base_i,
  input  logic [SIZE_W-1:0]  eff_size_i,
  input  logic [PAGES_W-1:0] page_count_i,
  output logic               push_o,
  output cmd_t               cmd_o
);

  logic [ADDR_W:0]   region_end;
  logic              outside;
  logic [ADDR_W-1:0] rel_full;

  // The region end is computed one bit wider so that it cannot wrap.
  assign region_end = {1'b0, base_i}
                    + (ADDR_W+1)'({page_count_i, {PAGE_SHIFT{1'b0}}});
  assign outside    = (req_i.free_address < base_i)
                    || ({1'b0, req_i.free_address} >= region_end);
  assign rel_full   = req_i.free_address - base_i;

  assign push_o = start_i && !busy_i;

  always_comb begin
    cmd_o.is_free    = (req_i.req_type == REQ_FREE);
    cmd_o.rel        = rel_full[REL_W-1:0];
    cmd_o.pre_status = ST_OK;
    if (req_i.req_type == REQ_FREE) begin
      if (outside) begin
        cmd_o.pre_status = ST_OUTSIDE;
      end
    end else begin
      if (req_i.req_size != eff_size_i) begin
        cmd_o.pre_status = ST_SIZE_MISMATCH;
      end
    end
  end

endmodule

@@ design/sfl_fifo.sv @@
// Short command queue between the front and back of the slab pool.
// Depends on sfl_pkg for the command type and depth.
module sfl_fifo import sfl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic full_o,
  output logic empty_o
);

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;

  assign full_o  = (fill_q == FILL_W'(QUEUE_DEPTH));
  assign empty_o = (fill_q == '0);
  assign cmd_o   = entries[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   fill_d = fill_q + 1'b1;
      2'b01:   fill_d = fill_q - 1'b1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

@@ design/sfl_div.sv @@
// Two-lane restoring divider, one quotient bit per lane per cycle, sharing
// one divisor. Depends on sfl_pkg for widths and the request/response types.
module sfl_div import sfl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int STEP_W = $clog2(REL_W + 1);

  logic [STEP_W-1:0] step_q;
  logic              done_q;
  logic [REL_W-1:0]  a_q, b_q;
  logic [SIZE_W-1:0] ra_q, rb_q;
  logic [SIZE_W-1:0] divisor_q;

  logic [SIZE_W:0]   trial_a, trial_b;
  logic              ge_a, ge_b;
  logic [SIZE_W-1:0] ra_next, rb_next;

  always_comb begin
    trial_a = {ra_q, a_q[REL_W-1]};
    trial_b = {rb_q, b_q[REL_W-1]};
    ge_a    = (trial_a >= {1'b0, divisor_q});
    ge_b    = (trial_b >= {1'b0, divisor_q});
    ra_next = ge_a ? SIZE_W'(trial_a - {1'b0, divisor_q}) : trial_a[SIZE_W-1:0];
    rb_next = ge_b ? SIZE_W'(trial_b - {1'b0, divisor_q}) : trial_b[SIZE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      step_q <= STEP_W'(REL_W);
      done_q <= 1'b0;
    end else begin
      done_q <= (step_q == STEP_W'(1));
      if (step_q != '0) begin
        step_q <= step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q       <= req_i.dividend_a;
      b_q       <= req_i.dividend_b;
      ra_q      <= '0;
      rb_q      <= '0;
      divisor_q <= req_i.divisor;
    end else if (step_q != '0) begin
      a_q  <= {a_q[REL_W-2:0], ge_a};
      b_q  <= {b_q[REL_W-2:0], ge_b};
      ra_q <= ra_next;
      rb_q <= rb_next;
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.quo_a = a_q;
  assign rsp_o.rem_a = ra_q;
  assign rsp_o.rem_b = rb_q;

endmodule

@@ design/sfl_back.sv @@
// Back end of the slab pool: link memory, head and count state, rebuild
// sweep and command execution. Depends on sfl_pkg and sfl_div.
module sfl_back import sfl_pkg::*; #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rebuild_i,
  input  logic [ADDR_W-1:0]  base_i,
  input  logic [SIZE_W-1:0]  eff_size_i,
  input  logic [PAGES_W-1:0] page_count_i,
  input  logic               cmd_valid_i,
  input  cmd_t               cmd_i,
  output logic               cmd_pop_o,
  output logic               rebuilding_o,
  output logic               rsp_valid_o,
  output rsp_t               rsp_o
);

  localparam int IDX_W = $clog2(MAX_SLOTS);
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);

  back_state_e state_q, state_d;

  logic [CNT_W-1:0]  used_q, used_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic              head_valid_q, head_valid_d;
  logic [IDX_W-1:0]  sweep_q, sweep_d;
  logic [ADDR_W-1:0] prod_q, prod_d;
  logic              rsp_valid_q, rsp_valid_d;
  rsp_t              rsp_q, rsp_d;

  logic [IDX_W:0]    link_mem [MAX_SLOTS];
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [IDX_W:0]    mem_wdata;
  logic              mem_re;
  logic [IDX_W:0]    rd_data_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic             is_full;
  logic             take_alloc, take_free;
  logic             sweep_last, sweep_link_valid;
  logic [CNT_W-1:0] sat_count;
  logic             free_ok;
  logic [CNT_W-1:0] used_inc, used_dec;

  sfl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    is_full          = (used_q >= count_q) || !head_valid_q;
    take_alloc       = cmd_valid_i && (cmd_i.pre_status == ST_OK) && !cmd_i.is_free
                       && !is_full;
    take_free        = cmd_valid_i && (cmd_i.pre_status == ST_OK) && cmd_i.is_free
                       && (used_q != '0);
    sweep_last       = (sweep_q == IDX_W'(MAX_SLOTS - 1));
    sweep_link_valid = ((CNT_W'(sweep_q) + 1'b1) < count_q);
    sat_count        = (div_rsp.quo_a > REL_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                          : CNT_W'(div_rsp.quo_a);
    free_ok          = (div_rsp.rem_a == '0) && (div_rsp.rem_b == '0)
                       && (div_rsp.quo_a < REL_W'(count_q));
    used_inc         = used_q + 1'b1;
    used_dec         = used_q - 1'b1;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_CNT_START: state_d = BK_CNT_WAIT;
      BK_CNT_WAIT:  if (div_rsp.done) state_d = BK_SWEEP;
      BK_SWEEP:     if (sweep_last) state_d = BK_IDLE;
      BK_IDLE: begin
        if (take_alloc) begin
          state_d = BK_ALLOC;
        end else if (take_free) begin
          state_d = BK_FREE_WAIT;
        end
      end
      BK_ALLOC:     state_d = BK_IDLE;
      BK_FREE_WAIT: if (div_rsp.done) state_d = BK_IDLE;
      default:      state_d = BK_CNT_START;
    endcase
    if (rebuild_i) begin
      state_d = BK_CNT_START;
    end
  end

  // Outputs and datapath updates.
  always_comb begin
    cmd_pop_o          = 1'b0;
    div_req.start      = 1'b0;
    div_req.dividend_a = cmd_i.rel;
    div_req.dividend_b = REL_W'(cmd_i.rel[PAGE_SHIFT-1:0]);
    div_req.divisor    = eff_size_i;
    mem_we             = 1'b0;
    mem_waddr          = sweep_q;
    mem_wdata          = {sweep_link_valid,
                          sweep_link_valid ? IDX_W'(sweep_q + 1'b1) : IDX_W'(0)};
    mem_re             = 1'b0;
    used_d             = used_q;
    count_d            = count_q;
    head_d             = head_q;
    head_valid_d       = head_valid_q;
    sweep_d            = sweep_q;
    prod_d             = prod_q;
    rsp_valid_d        = 1'b0;
    rsp_d              = rsp_q;
    rsp_d.slot_address = '0;
    rsp_d.in_use       = IN_USE_W'(used_q);

    case (state_q)
      BK_CNT_START: begin
        div_req.start      = 1'b1;
        div_req.dividend_a = {page_count_i, {PAGE_SHIFT{1'b0}}};
        used_d             = '0;
        head_d             = '0;
        sweep_d            = '0;
      end
      BK_CNT_WAIT: begin
        if (div_rsp.done) begin
          count_d      = sat_count;
          head_valid_d = (sat_count != '0);
        end
      end
      BK_SWEEP: begin
        mem_we  = 1'b1;
        sweep_d = sweep_q + 1'b1;
      end
      BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.pre_status != ST_OK) begin
            rsp_valid_d  = 1'b1;
            rsp_d.status = cmd_i.pre_status;
          end else if (!cmd_i.is_free) begin
            if (is_full) begin
              rsp_valid_d  = 1'b1;
              rsp_d.status = ST_FULL;
            end else begin
              mem_re = 1'b1;
              prod_d = ADDR_W'(head_q) * ADDR_W'(eff_size_i);
            end
          end else begin
            if (used_q == '0) begin
              rsp_valid_d  = 1'b1;
              rsp_d.status = ST_NONE_OUT;
            end else begin
              div_req.start = 1'b1;
            end
          end
        end
      end
      BK_ALLOC: begin
        rsp_valid_d        = 1'b1;
        rsp_d.status       = ST_OK;
        rsp_d.slot_address = base_i + prod_q;
        rsp_d.in_use       = IN_USE_W'(used_inc);
        used_d             = used_inc;
        head_d             = rd_data_q[IDX_W-1:0];
        head_valid_d       = rd_data_q[IDX_W];
      end
      BK_FREE_WAIT: begin
        if (div_rsp.done) begin
          rsp_valid_d = 1'b1;
          if (free_ok) begin
            mem_we       = 1'b1;
            mem_waddr    = IDX_W'(div_rsp.quo_a);
            mem_wdata    = {head_valid_q, head_q};
            head_d       = IDX_W'(div_rsp.quo_a);
            head_valid_d = 1'b1;
            used_d       = used_dec;
            rsp_d.status = ST_OK;
            rsp_d.in_use = IN_USE_W'(used_dec);
          end else begin
            rsp_d.status = ST_MISALIGNED;
          end
        end
      end
      default: begin
        rsp_valid_d = 1'b0;
      end
    endcase
  end

  assign rebuilding_o = (state_q == BK_CNT_START) || (state_q == BK_CNT_WAIT)
                      || (state_q == BK_SWEEP);
  assign rsp_valid_o  = rsp_valid_q;
  assign rsp_o        = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_CNT_START;
      used_q       <= '0;
      count_q      <= '0;
      head_q       <= '0;
      head_valid_q <= 1'b0;
      sweep_q      <= '0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      used_q       <= used_d;
      count_q      <= count_d;
      head_q       <= head_d;
      head_valid_q <= head_valid_d;
      sweep_q      <= sweep_d;
      rsp_valid_q  <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rsp_q  <= rsp_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_data_q <= link_mem[head_q];
    end
  end

`ifndef SYNTHESIS
  a_used_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= count_q)
    else $error("outstanding count exceeds slot count");

  a_alloc_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_ALLOC |=> rsp_valid_q && (rsp_q.status == ST_OK))
    else $error("allocation did not produce a successful result");

  a_pre_err_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_IDLE) && cmd_valid_i && (cmd_i.pre_status != ST_OK)
    |=> rsp_valid_q && (rsp_q.status == $past(cmd_i.pre_status)))
    else $error("front-end error not reported in the next cycle");

  a_err_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && (rsp_q.status != ST_OK) |-> (rsp_q.slot_address == '0))
    else $error("error result carries a slot address");
`endif

endmodule

@@ design/slab_free_list_pool_core.sv @@
// Top level of the slab free-list pool: configuration registers and the
// front, queue and back instances. Depends on sfl_pkg and all sfl_* modules.
//
// Usage: a request item is taken on a rising edge with start high and busy
// low; req_i carries the type (allocate or free), the allocate size and the
// address being freed. Each item yields exactly one result item, shown on
// rsp_o for a single cycle while rsp_valid_o is high; the receiver cannot
// stall, so results must be captured when the strobe is seen.
// An allocate passes through the command queue, the idle state, the
// allocate state and the result register; a free waits on the serial
// divider, which turns the address offset into a slot index at one bit per
// cycle. Up to two items wait in the command queue; busy rises when full.
// Configuration registers are written through cfg_we_i, cfg_idx_i and
// cfg_data_i, one per cycle; the user must write them only while no item is
// in flight; the block does not enforce it. After reset and after every
// register write the pool is rebuilt: the slot count is divided out, the
// link memory is swept one entry per cycle, and busy stays high throughout.
module slab_free_list_pool_core import sfl_pkg::*; #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  req_t                 req_i,
  output logic                 rsp_valid_o,
  output rsp_t                 rsp_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ADDR_W-1:0]    cfg_data_i
);

  logic [ADDR_W-1:0]  base_q, base_d;
  logic [SIZE_W-1:0]  slot_size_q, slot_size_d;
  logic [PAGES_W-1:0] page_count_q, page_count_d;
  logic [SIZE_W-1:0]  eff_size;
  logic               rebuild;

  logic push;
  cmd_t push_cmd;
  cmd_t head_cmd;
  logic queue_full, queue_empty;
  logic cmd_pop;
  logic rebuilding;

  // Register writes. Any write to a known register restarts the rebuild;
  // writes to an unused index are dropped.
  always_comb begin
    base_d       = base_q;
    slot_size_d  = slot_size_q;
    page_count_d = page_count_q;
    rebuild      = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BASE: begin
          base_d  = cfg_data_i & PAGE_MASK;
          rebuild = 1'b1;
        end
        CFG_SLOT_SIZE: begin
          slot_size_d = cfg_data_i[SIZE_W-1:0];
          rebuild     = 1'b1;
        end
        CFG_PAGE_COUNT: begin
          page_count_d = cfg_data_i[PAGES_W-1:0];
          rebuild      = 1'b1;
        end
        default: begin
          rebuild = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q       <= RESET_BASE;
      slot_size_q  <= RESET_SLOT_SIZE;
      page_count_q <= RESET_PAGES;
    end else begin
      base_q       <= base_d;
      slot_size_q  <= slot_size_d;
      page_count_q <= page_count_d;
    end
  end

  // Slot sizes below the pointer size behave as the pointer size.
  assign eff_size = (slot_size_q < MIN_SLOT) ? MIN_SLOT : slot_size_q;

  // New items are held off while the queue is full or the pool is rebuilt.
  assign busy = queue_full || rebuilding;

  sfl_front u_front (
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req_i),
    .base_i       (base_q),
    .eff_size_i   (eff_size),
    .page_count_i (page_count_q),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  sfl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (cmd_pop),
    .cmd_o   (head_cmd),
    .full_o  (queue_full),
    .empty_o (queue_empty)
  );

  sfl_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rebuild_i    (rebuild),
    .base_i       (base_q),
    .eff_size_i   (eff_size),
    .page_count_i (page_count_q),
    .cmd_valid_i  (!queue_empty),
    .cmd_i        (head_cmd),
    .cmd_pop_o    (cmd_pop),
    .rebuilding_o (rebuilding),
    .rsp_valid_o  (rsp_valid_o),
    .rsp_o        (rsp_o)
  );

endmodule
